FILE: rtl/eps_pkg.sv
// ----------------------------------------------------------------------------
// eps_pkg
// Shared types and constants for the epoch seconds to UTC date converter.
// ----------------------------------------------------------------------------
package eps_pkg;

   localparam int unsigned PIPE_DEPTH = 6;

   localparam logic [31:0] LIMIT_SECONDS = 32'd4102444800;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
   } eps_clock_type;

   typedef struct packed {
      logic [2:0] weekday;
      logic [7:0] years_since_1900;
      logic [8:0] day_of_year;
      logic [3:0] month;
      logic [4:0] day_of_month;
   } eps_date_type;

endpackage

FILE: rtl/eps_day_split.sv
// ----------------------------------------------------------------------------
// eps_day_split
// Two stages: seconds split into whole days and seconds within the day.
// ----------------------------------------------------------------------------
module eps_day_split
   import eps_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] epoch_seconds,
   output logic [15:0] days,
   output logic [16:0] day_seconds
);

   localparam logic [25:0] DAY_RECIP = 26'd50903317;
   localparam int unsigned DAY_SHIFT = 35;

   logic [31:0] secs_ff;
   logic [50:0] dprod_ff;
   logic [50:0] dprod_in;
   logic [15:0] days_ff;
   logic [15:0] days_in;
   logic [16:0] dsec_ff;
   logic [16:0] dsec_in;
   logic [32:0] day_base;

   always_comb begin
      dprod_in = 51'(epoch_seconds[31:7]) * 51'(DAY_RECIP);
      days_in  = dprod_ff[DAY_SHIFT+15:DAY_SHIFT];
      day_base = 33'(days_in) * 33'd86400;
      dsec_in  = 17'(33'(secs_ff) - day_base);
   end

   always_ff @(posedge clock) begin
      secs_ff  <= epoch_seconds;
      dprod_ff <= dprod_in;
      days_ff  <= days_in;
      dsec_ff  <= dsec_in;
   end

   assign days        = days_ff;
   assign day_seconds = dsec_ff;

endmodule

FILE: rtl/eps_time_of_day.sv
// ----------------------------------------------------------------------------
// eps_time_of_day
// Four stages: seconds within the day to hour, minute and second.
// ----------------------------------------------------------------------------
module eps_time_of_day
   import eps_pkg::*;
(
   input  logic          clock,
   input  logic [16:0]   day_seconds,
   output eps_clock_type clock_fields
);

   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam logic [10:0] MIN_RECIP  = 11'd1093;

   logic [26:0]   hprod_ff;
   logic [26:0]   hprod_in;
   logic [16:0]   dsec_ff;
   logic [4:0]    hour_ff;
   logic [4:0]    hour_in;
   logic [11:0]   hsec_ff;
   logic [11:0]   hsec_in;
   logic [4:0]    hour2_ff;
   logic [20:0]   mprod_ff;
   logic [20:0]   mprod_in;
   logic [11:0]   hsec2_ff;
   logic [5:0]    minute_in;
   logic [5:0]    second_in;
   eps_clock_type out_ff;

   always_comb begin
      hprod_in  = 27'(day_seconds[16:4]) * 27'(HOUR_RECIP);
      hour_in   = hprod_ff[25:21];
      hsec_in   = 12'(dsec_ff - 17'(hour_in) * 17'd3600);
      mprod_in  = 21'(hsec_ff[11:2]) * 21'(MIN_RECIP);
      minute_in = mprod_ff[19:14];
      second_in = 6'(hsec2_ff - 12'(minute_in) * 12'd60);
   end

   always_ff @(posedge clock) begin
      hprod_ff         <= hprod_in;
      dsec_ff          <= day_seconds;
      hour_ff          <= hour_in;
      hsec_ff          <= hsec_in;
      hour2_ff         <= hour_ff;
      mprod_ff         <= mprod_in;
      hsec2_ff         <= hsec_ff;
      out_ff.hour      <= hour2_ff;
      out_ff.minute    <= minute_in;
      out_ff.second    <= second_in;
   end

   assign clock_fields = out_ff;

endmodule

FILE: rtl/eps_calendar.sv
// ----------------------------------------------------------------------------
// eps_calendar
// Four stages: day count to weekday, year, day of year, month and day of month.
// ----------------------------------------------------------------------------
module eps_calendar
   import eps_pkg::*;
(
   input  logic         clock,
   input  logic [15:0]  days,
   output eps_date_type date_fields
);

   localparam logic [16:0] CYCLE_RECIP = 17'd91868;
   localparam logic [16:0] WEEK_RECIP  = 17'd74899;

   localparam logic [8:0] START_NORMAL [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };
   localparam logic [8:0] START_LEAP [12] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
   };

   // stage 3
   logic [15:0] shifted_in;
   logic [15:0] wday_in;
   logic [32:0] cprod_in;
   logic [32:0] wprod_in;
   logic [15:0] shifted_ff;
   logic [15:0] wday_ff;
   logic [32:0] cprod_ff;
   logic [32:0] wprod_ff;
   // stage 4
   logic [5:0]  cycle_in;
   logic [10:0] cday_in;
   logic [2:0]  weekday_in;
   logic [5:0]  cycle_ff;
   logic [10:0] cday_ff;
   logic [2:0]  weekday_ff;
   // stage 5
   logic [1:0]  yin;
   logic [10:0] year_base;
   logic [7:0]  year_in;
   logic [8:0]  doy_in;
   logic        leap_in;
   logic [7:0]  year_ff;
   logic [8:0]  doy_ff;
   logic        leap_ff;
   logic [2:0]  weekday2_ff;
   // stage 6
   logic [3:0]  month_in;
   logic [8:0]  mstart;
   logic [4:0]  dom_in;
   eps_date_type out_ff;

   always_comb begin
      shifted_in = days + 16'd365;
      wday_in    = days + 16'd4;
      cprod_in   = 33'(shifted_in) * 33'(CYCLE_RECIP);
      wprod_in   = 33'(wday_in) * 33'(WEEK_RECIP);

      cycle_in   = cprod_ff[32:27];
      cday_in    = 11'(shifted_ff - 16'(cycle_in) * 16'd1461);
      weekday_in = 3'(wday_ff - 16'(wprod_ff[32:19]) * 16'd7);

      priority if (cday_ff >= 11'd1095) begin
         yin       = 2'd3;
         year_base = 11'd1095;
      end else if (cday_ff >= 11'd730) begin
         yin       = 2'd2;
         year_base = 11'd730;
      end else if (cday_ff >= 11'd365) begin
         yin       = 2'd1;
         year_base = 11'd365;
      end else begin
         yin       = 2'd0;
         year_base = 11'd0;
      end
      year_in = 8'd69 + {cycle_ff, 2'b00} + {6'd0, yin};
      doy_in  = 9'(cday_ff - year_base);
      leap_in = (yin == 2'd3);

      month_in = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (doy_ff >= (leap_ff ? START_LEAP[m] : START_NORMAL[m])) begin
            month_in = 4'(m);
         end
      end
      mstart = leap_ff ? START_LEAP[month_in] : START_NORMAL[month_in];
      dom_in = 5'(doy_ff - mstart + 9'd1);
   end

   always_ff @(posedge clock) begin
      shifted_ff <= shifted_in;
      wday_ff    <= wday_in;
      cprod_ff   <= cprod_in;
      wprod_ff   <= wprod_in;

      cycle_ff   <= cycle_in;
      cday_ff    <= cday_in;
      weekday_ff <= weekday_in;

      year_ff     <= year_in;
      doy_ff      <= doy_in;
      leap_ff     <= leap_in;
      weekday2_ff <= weekday_ff;

      out_ff.weekday          <= weekday2_ff;
      out_ff.years_since_1900 <= year_ff;
      out_ff.day_of_year      <= doy_ff;
      out_ff.month            <= month_in;
      out_ff.day_of_month     <= dom_in;
   end

   assign date_fields = out_ff;

endmodule

FILE: rtl/epoch_seconds_to_utc_date.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_date
// Converts seconds since 1970-01-01 00:00:00 UTC to the broken-down UTC date.
// ----------------------------------------------------------------------------
// A beat can be started on every cycle; busy stays low, and the receiver
// cannot stall. Each result appears with rsp_valid for one cycle, in order.
// The pipeline depth is set by the chain of constant reciprocal multiplies
// (days, then four-year cycles, hours and minutes), each followed by a
// register before the back-multiply that forms the remainder. Inputs from
// 2100-01-01 on raise rsp_out_of_range with all other fields zero.
module epoch_seconds_to_utc_date
   import eps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   output logic [5:0]  rsp_second,
   output logic [5:0]  rsp_minute,
   output logic [4:0]  rsp_hour,
   output logic [2:0]  rsp_weekday,
   output logic [7:0]  rsp_years_since_1900,
   output logic [8:0]  rsp_day_of_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic        rsp_out_of_range
);

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic [PIPE_DEPTH-1:0] oor_ff;
   logic [PIPE_DEPTH-1:0] oor_in;
   logic                  accept;
   logic [15:0]           days;
   logic [16:0]           day_seconds;
   eps_clock_type         clock_fields;
   eps_date_type          date_fields;
   logic                  drop;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_comb begin
      valid_in = {valid_ff[PIPE_DEPTH-2:0], accept};
      oor_in   = {oor_ff[PIPE_DEPTH-2:0], (req_epoch_seconds >= LIMIT_SECONDS)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      oor_ff <= oor_in;
   end

   eps_day_split u_day_split (
      .clock         (clock),
      .epoch_seconds (req_epoch_seconds),
      .days          (days),
      .day_seconds   (day_seconds)
   );

   eps_time_of_day u_time_of_day (
      .clock        (clock),
      .day_seconds  (day_seconds),
      .clock_fields (clock_fields)
   );

   eps_calendar u_calendar (
      .clock       (clock),
      .days        (days),
      .date_fields (date_fields)
   );

   assign drop = oor_ff[PIPE_DEPTH-1];

   assign rsp_valid            = valid_ff[PIPE_DEPTH-1];
   assign rsp_out_of_range     = drop;
   assign rsp_second           = drop ? '0 : clock_fields.second;
   assign rsp_minute           = drop ? '0 : clock_fields.minute;
   assign rsp_hour             = drop ? '0 : clock_fields.hour;
   assign rsp_weekday          = drop ? '0 : date_fields.weekday;
   assign rsp_years_since_1900 = drop ? '0 : date_fields.years_since_1900;
   assign rsp_day_of_year      = drop ? '0 : date_fields.day_of_year;
   assign rsp_month            = drop ? '0 : date_fields.month;
   assign rsp_day_of_month     = drop ? '0 : date_fields.day_of_month;

endmodule

FILE: rtl/eps_checker.sv
// ----------------------------------------------------------------------------
// eps_checker
// Port-level checks on latency, range handling and field bounds.
// ----------------------------------------------------------------------------
module eps_checker
   import eps_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_epoch_seconds,
   input logic        rsp_valid,
   input logic [5:0]  rsp_second,
   input logic [5:0]  rsp_minute,
   input logic [4:0]  rsp_hour,
   input logic [2:0]  rsp_weekday,
   input logic [7:0]  rsp_years_since_1900,
   input logic [8:0]  rsp_day_of_year,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day_of_month,
   input logic        rsp_out_of_range
);

   a_beat_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH rsp_valid)
      else $error("result beat missing at fixed latency");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##PIPE_DEPTH !rsp_valid)
      else $error("result beat without a start");

   a_range_flag : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH
      (rsp_out_of_range == ($past(req_epoch_seconds, PIPE_DEPTH) >= LIMIT_SECONDS)))
      else $error("out-of-range flag mismatch");

   a_oor_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
      (rsp_second == '0 && rsp_minute == '0 && rsp_hour == '0 && rsp_weekday == '0 &&
       rsp_years_since_1900 == '0 && rsp_day_of_year == '0 && rsp_month == '0 &&
       rsp_day_of_month == '0))
      else $error("out-of-range beat carries nonzero fields");

   a_bounds : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_of_range) |->
      (rsp_second < 6'd60 && rsp_minute < 6'd60 && rsp_hour < 5'd24 &&
       rsp_weekday < 3'd7 && rsp_month < 4'd12 && rsp_day_of_month != 5'd0 &&
       rsp_years_since_1900 >= 8'd70 && rsp_day_of_year < 9'd366))
      else $error("date field out of bounds");

endmodule

bind epoch_seconds_to_utc_date eps_checker u_eps_checker (.*);

FILE: test/utc_date_checker.sv
// ----------------------------------------------------------------------------
// utc_date_checker
// Watches the start/busy beat and the result strobe of the epoch seconds to
// UTC date converter. Each accepted beat is converted to the expected calendar
// fields and queued; each result beat is compared field by field with the
// oldest queued date.
// ----------------------------------------------------------------------------
module utc_date_checker
   import eps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_epoch_seconds,
   input  logic        rsp_valid,
   input  logic [5:0]  rsp_second,
   input  logic [5:0]  rsp_minute,
   input  logic [4:0]  rsp_hour,
   input  logic [2:0]  rsp_weekday,
   input  logic [7:0]  rsp_years_since_1900,
   input  logic [8:0]  rsp_day_of_year,
   input  logic [3:0]  rsp_month,
   input  logic [4:0]  rsp_day_of_month,
   input  logic        rsp_out_of_range,
   output int          mismatch_count,
   output int          pending,
   output int          beats_seen,
   output int          beyond_2099_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      eps_clock_type clk;
      eps_date_type  date;
      logic          out_of_range;
   } utc_fields_type;

   // first day of each month in a common year
   int unsigned month_first [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   utc_fields_type expected_dates [$];

   function automatic utc_fields_type civil_from_epoch(logic [31:0] secs);
      utc_fields_type f;
      int unsigned days, sod, span, quad, pos, yr_in_quad, doy, mon, first;
      logic leap;
      f = '0;
      if (secs >= LIMIT_SECONDS) begin
         f.out_of_range = 1'b1;
         return f;
      end
      days = secs / 86400;
      sod  = secs % 86400;
      // count from 1969 so each four-year span ends on its leap year
      span = days + 365;
      quad = span / 1461;
      pos  = span % 1461;
      yr_in_quad = pos / 365;
      if (yr_in_quad > 3)
         yr_in_quad = 3;
      doy  = pos - 365 * yr_in_quad;
      leap = (yr_in_quad == 3);
      mon  = 11;
      first = month_first[11] + leap;
      while (mon > 0 && doy < first) begin
         mon--;
         first = month_first[mon] + ((leap && mon >= 2) ? 1 : 0);
      end
      f.clk.second  = 6'(sod % 60);
      f.clk.minute  = 6'((sod % 3600) / 60);
      f.clk.hour    = 5'(sod / 3600);
      f.date.weekday          = 3'((days + 4) % 7);
      f.date.years_since_1900 = 8'(69 + 4 * quad + yr_in_quad);
      f.date.day_of_year      = 9'(doy);
      f.date.month            = 4'(mon);
      f.date.day_of_month     = 5'(doy - first + 1);
      return f;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   initial begin
      mismatch_count   = 0;
      pending          = 0;
      beats_seen       = 0;
      beyond_2099_seen = 0;
   end

   always @(posedge clock) begin
      utc_fields_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_dates.size() == 0) begin
               report_mismatch("unexpected result beat", 1, 0);
            end else begin
               want = expected_dates.pop_front();
               if (rsp_out_of_range !== want.out_of_range)
                  report_mismatch("out_of_range", rsp_out_of_range, want.out_of_range);
               if (rsp_second !== want.clk.second)
                  report_mismatch("second", rsp_second, want.clk.second);
               if (rsp_minute !== want.clk.minute)
                  report_mismatch("minute", rsp_minute, want.clk.minute);
               if (rsp_hour !== want.clk.hour)
                  report_mismatch("hour", rsp_hour, want.clk.hour);
               if (rsp_weekday !== want.date.weekday)
                  report_mismatch("weekday", rsp_weekday, want.date.weekday);
               if (rsp_years_since_1900 !== want.date.years_since_1900)
                  report_mismatch("years_since_1900", rsp_years_since_1900,
                                  want.date.years_since_1900);
               if (rsp_day_of_year !== want.date.day_of_year)
                  report_mismatch("day_of_year", rsp_day_of_year, want.date.day_of_year);
               if (rsp_month !== want.date.month)
                  report_mismatch("month", rsp_month, want.date.month);
               if (rsp_day_of_month !== want.date.day_of_month)
                  report_mismatch("day_of_month", rsp_day_of_month, want.date.day_of_month);
            end
         end
         if (start && !busy) begin
            want = civil_from_epoch(req_epoch_seconds);
            expected_dates.push_back(want);
            beats_seen++;
            if (want.out_of_range)
               beyond_2099_seen++;
         end
         pending <= expected_dates.size();
      end
   end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives epoch second counts into the UTC date converter: a directed set of
// calendar edges (epoch start, leap days, year ends, the 2038 sign boundary,
// the 2100 limit and the top of the 32-bit range), then random counts biased
// toward day edges and the limit, under several rates of sender idling.
// ----------------------------------------------------------------------------
module testbench;
   import eps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LAST_DAY   = 47481;  // 2099-12-31 as a day count
   localparam int          RANDOM_PER_PHASE = 238;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic [5:0]  rsp_second;
   logic [5:0]  rsp_minute;
   logic [4:0]  rsp_hour;
   logic [2:0]  rsp_weekday;
   logic [7:0]  rsp_years_since_1900;
   logic [8:0]  rsp_day_of_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic        rsp_out_of_range;

   int mismatch_count, pending, beats_seen, beyond_2099_seen;
   int idle_pct;

   always #1 clock = ~clock;

   epoch_seconds_to_utc_date uut (.*);

   utc_date_checker date_checker (.*);

   // hold idle for a random stretch, then put one beat on the request port
   task automatic issue_seconds(logic [31:0] secs);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < idle_pct);
      end
      start <= 1'b1;
      req_epoch_seconds <= secs;
      do
         @(posedge clock);
      while (busy);
   endtask

   function automatic logic [31:0] random_seconds();
      int unsigned pick, day;
      pick = $urandom_range(0, 99);
      day  = $urandom_range(0, LAST_DAY);
      if (pick < 55)
         return $urandom_range(0, LIMIT_SECONDS - 1);
      else if (pick < 70)
         return $urandom();
      else if (pick < 80)
         return day * 86400 + $urandom_range(0, 2);
      else if (pick < 90)
         return day * 86400 + $urandom_range(86397, 86399);
      else if (pick < 95)
         return LIMIT_SECONDS - 1 - $urandom_range(0, 200000);
      else
         return LIMIT_SECONDS + $urandom_range(0, 3);
   endfunction

   initial begin
      logic [31:0] directed [$];
      directed = '{32'd0, 32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
                   32'd68169600, 32'd68255999, 32'd94694399, 32'd94694400,
                   32'd951782400, 32'd951868800, 32'd978307199, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'd4102358400, LIMIT_SECONDS - 1, LIMIT_SECONDS,
                   LIMIT_SECONDS + 1, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
      idle_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         issue_seconds(directed[i]);

      for (int phase = 0; phase < 4; phase++) begin
         unique case (phase)
            0: idle_pct = 0;
            1: idle_pct = 73;
            2: idle_pct = 37;
            default: idle_pct = 0;
         endcase
         repeat (RANDOM_PER_PHASE)
            issue_seconds(random_seconds());
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);

      $display("summary: %0d conversions checked, %0d past 2099, %0d mismatches",
               beats_seen, beyond_2099_seen, mismatch_count);
      if (mismatch_count == 0 && pending == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", pending);
      $display("testbench: FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/eps_pkg.sv
rtl/eps_day_split.sv
rtl/eps_time_of_day.sv
rtl/eps_calendar.sv
rtl/epoch_seconds_to_utc_date.sv
rtl/eps_checker.sv
test/utc_date_checker.sv
test/testbench.sv
